// ===== rtl/ffba_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and defaults of the first-fit block allocator.
package ffba_pkg;

  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES = 12;
  localparam int DEF_ALIGN_BYTES  = 4;

  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int REQ_W    = 2 * DATA_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 2'd1;

  localparam logic [DATA_W-1:0] HEAP_START_RST = 32'd0;
  localparam logic [DATA_W-1:0] HEAP_END_RST   = 32'd65536;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NULL      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RESP
  } state_e;

  // One row of the block table.
  typedef struct packed {
    logic [DATA_W-1:0] offset;
    logic [DATA_W-1:0] size;
    logic              is_free;
  } entry_t;

endpackage

// ===== rtl/ffba_table.sv =====
`timescale 1ns / 1ps
// Block table memory: one write port and one registered read port.
module ffba_table #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output ffba_pkg::entry_t     rd_data_o,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  ffba_pkg::entry_t     wr_data_i
);
  import ffba_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/ffba_align.sv =====
`timescale 1ns / 1ps
// Rounds a request size up to the alignment with a reciprocal multiplication.
module ffba_align #(
  parameter int ALIGN_BYTES = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ffba_pkg::DATA_W-1:0] size_i,
  output logic                        done_o,
  output logic [ffba_pkg::DATA_W-1:0] rounded_o
);
  import ffba_pkg::*;

  // The quotient size / ALIGN_BYTES equals (size * RECIP) >> RECIP_SH for every
  // 32-bit size, because the scaled reciprocal is rounded up by less than one
  // alignment step.
  localparam int RECIP_SH = DATA_W + $clog2(ALIGN_BYTES);
  localparam int RECIP_W  = DATA_W + 1;
  localparam int PROD_W   = RECIP_SH + DATA_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RECIP_SH) + 64'(ALIGN_BYTES - 1)) / 64'(ALIGN_BYTES);
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_L[RECIP_W-1:0];
  localparam logic [DATA_W-1:0]  ALIGN_V = DATA_W'(ALIGN_BYTES);

  logic              mul_q, fix_q, done_q;
  logic [DATA_W-1:0] value_q, quot_q, rounded_q;
  logic [PROD_W-1:0] prod;
  logic [DATA_W-1:0] rem, pad;

  assign prod = PROD_W'(value_q) * PROD_W'(RECIP);
  assign rem  = value_q - quot_q * ALIGN_V;
  assign pad  = (rem == '0) ? '0 : (ALIGN_V - rem);

  // Three stages: latch the size, multiply, then pad up to the next multiple.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q <= start_i;
      fix_q <= mul_q;
      if (start_i) begin
        done_q <= 1'b0;
      end else if (fix_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      value_q <= size_i;
    end
    if (mul_q) begin
      quot_q <= prod[RECIP_SH +: DATA_W];
    end
    if (fix_q) begin
      rounded_q <= value_q + pad;
    end
  end

  assign done_o    = done_q;
  assign rounded_o = rounded_q;

endmodule

// ===== rtl/first_fit_block_allocator_top.sv =====
`timescale 1ns / 1ps
// Top level of the first-fit block allocator: request control and result register.
//
// Requests enter on the s_axis channel: tuser carries the kind (allocate or
// free), tdata carries the request size and the release address. Each request
// yields exactly one result transaction on m_axis: the payload address in
// tdata and the status code in tuser.
// The heap bounds are written through the cfg channel, which is always ready;
// writes are expected only while no request is in flight.
// A request is handled one at a time. Null requests, overflowing sizes and frees
// on an empty table go straight to the result. Otherwise the block table memory
// is read one entry per cycle in address order until a hit or the last entry;
// an allocate that misses also waits for the alignment unit. A full table is
// reported only after every entry is read through the single read port.
// The result sits in an output register, so a stalled receiver only blocks
// the next request once its result is ready and the register is still full.
// Reset empties the table (block count and heap top go to zero) and restores
// heap_start to 0 and heap_end to 65536; table contents need no clearing.
module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
  parameter int ALIGN_BYTES  = ffba_pkg::DEF_ALIGN_BYTES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: request_size [31:0], release_address [63:32].
  input  logic [ffba_pkg::REQ_W-1:0]     s_axis_tdata_i,
  // tuser: kind [0].
  input  logic                           s_axis_tuser_i,
  // Result channel.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: payload_address [31:0].
  output logic [ffba_pkg::DATA_W-1:0]    m_axis_tdata_o,
  // tuser: status [2:0].
  output logic [ffba_pkg::STATUS_W-1:0]  m_axis_tuser_o,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ffba_pkg::DATA_W-1:0]    cfg_data_i
);
  import ffba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int END_W = DATA_W + 2;
  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_BLOCKS);
  localparam logic [DATA_W-1:0] HDR     = DATA_W'(HEADER_BYTES);
  // Largest size whose round-up still fits in 32 bits.
  localparam longint unsigned SIZE_LIMIT_L =
    (64'hFFFF_FFFF / ALIGN_BYTES) * ALIGN_BYTES;
  localparam logic [DATA_W-1:0] SIZE_LIMIT = SIZE_LIMIT_L[DATA_W-1:0];

  state_e            state_q, state_d;
  logic [DATA_W-1:0] heap_start_q, heap_end_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] top_q, top_d;

  kind_e             kind_q;
  logic [DATA_W-1:0] size_q, target_q;
  logic [END_W-1:0]  base_q;
  logic [IDX_W-1:0]  idx_q, idx_d;

  logic [DATA_W-1:0] res_addr_q, res_addr_d;
  status_e           res_status_q, res_status_d;

  logic              out_valid_q, out_load;
  logic [DATA_W-1:0] out_addr_q;
  status_e           out_status_q;

  logic              accept;
  logic [DATA_W-1:0] req_size, req_addr;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  entry_t            rd_data, wr_data;

  logic              align_start, align_done;
  logic [DATA_W-1:0] rounded;

  logic              hit, last;
  logic [END_W-1:0]  end_addr;

  assign req_size = s_axis_tdata_i[DATA_W-1:0];
  assign req_addr = s_axis_tdata_i[REQ_W-1:DATA_W];
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;

  ffba_table #(
    .DEPTH (MAX_BLOCKS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  ffba_align #(
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_align (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (align_start),
    .size_i    (req_size),
    .done_o    (align_done),
    .rounded_o (rounded)
  );

  // Configuration registers; an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q <= HEAP_START_RST;
      heap_end_q   <= HEAP_END_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_HEAP_START) begin
        heap_start_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_HEAP_END) begin
        heap_end_q <= cfg_data_i;
      end
    end
  end

  // Request fields are latched at acceptance. The free target is the header
  // offset that a matching entry must hold, so the scan compares directly.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_e'(s_axis_tuser_i);
      size_q   <= req_size;
      target_q <= req_addr - heap_start_q - HDR;
      base_q   <= END_W'(heap_start_q) + END_W'(top_q) + END_W'(HDR);
    end
  end

  // A stored size is always a multiple of the alignment, so comparing it to
  // the unrounded size gives the same answer as comparing it to the rounded.
  assign hit = (kind_q == KIND_ALLOC) ? (rd_data.is_free && (rd_data.size >= size_q))
                                      : (rd_data.offset == target_q);
  assign last     = (CNT_W'(idx_q) + 1'b1) == count_q;
  assign end_addr = base_q + END_W'(rounded);

  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    count_d         = count_q;
    top_d           = top_q;
    res_addr_d      = res_addr_q;
    res_status_d    = res_status_q;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = idx_q;
    wr_data         = rd_data;
    align_start     = 1'b0;
    out_load        = 1'b0;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        res_addr_d      = '0;
        if (s_axis_tvalid_i) begin
          idx_d = '0;
          if (kind_e'(s_axis_tuser_i) == KIND_ALLOC) begin
            if (req_size == '0) begin
              res_status_d = ST_NULL;
              state_d      = S_RESP;
            end else if (req_size > SIZE_LIMIT) begin
              res_status_d = ST_OVERFLOW;
              state_d      = S_RESP;
            end else begin
              align_start = 1'b1;
              if (count_q == '0) begin
                state_d = S_DECIDE;
              end else begin
                rd_en   = 1'b1;
                state_d = S_SCAN;
              end
            end
          end else begin
            if (req_addr == '0) begin
              res_status_d = ST_NULL;
              state_d      = S_RESP;
            end else if (count_q == '0) begin
              res_status_d = ST_UNKNOWN;
              state_d      = S_RESP;
            end else begin
              rd_en   = 1'b1;
              state_d = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          // Read-modify-write of the matching entry: only the free flag moves.
          wr_en           = 1'b1;
          wr_data.is_free = (kind_q == KIND_FREE);
          res_status_d    = ST_OK;
          res_addr_d      = (kind_q == KIND_ALLOC) ? (heap_start_q + rd_data.offset + HDR)
                                                   : '0;
          state_d         = S_RESP;
        end else if (last) begin
          if (kind_q == KIND_ALLOC) begin
            state_d = S_DECIDE;
          end else begin
            res_status_d = ST_UNKNOWN;
            state_d      = S_RESP;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_q + 1'b1;
        end
      end

      S_DECIDE: begin
        if (count_q == MAX_CNT) begin
          res_status_d = ST_FULL;
          state_d      = S_RESP;
        end else if (align_done) begin
          if (end_addr > END_W'(heap_end_q)) begin
            res_status_d = ST_EXHAUSTED;
          end else begin
            // Carve a new block from the heap top.
            wr_en           = 1'b1;
            wr_addr         = count_q[IDX_W-1:0];
            wr_data.offset  = top_q;
            wr_data.size    = rounded;
            wr_data.is_free = 1'b0;
            count_d         = count_q + 1'b1;
            top_d           = top_q + HDR + rounded;
            res_addr_d      = base_q[DATA_W-1:0];
            res_status_d    = ST_OK;
          end
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      top_q   <= top_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_addr_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule
